### rtl/core/dil_pkg.sv
// Shared constants and types for the binary square dilation block.
package dil_pkg;

    // Default sizing of the grid and the window
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_RADIUS_DEF = 15;

    // Register reset values
    localparam int GRID_WIDTH_RST     = 1024;
    localparam int GRID_HEIGHT_RST    = 1024;
    localparam int INFLATE_RADIUS_RST = 1;

    // Configuration port layout
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int RADIUS_FIELD_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INFLATE_RADIUS = 2'd2;

    // Result queue depth, a power of two
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic inflated_occupied;
        logic frame_last;
    } result_t;

endpackage

### rtl/core/dil_ifs.sv
// Handshake channel interfaces for cells, results and configuration.
interface dil_cell_if;
    logic valid;
    logic ready;
    logic mode;
    logic cell_occupied;

    modport source (output valid, output mode, output cell_occupied, input ready);
    modport sink (input valid, input mode, input cell_occupied, output ready);
endinterface

interface dil_result_if;
    logic valid;
    logic ready;
    logic inflated_occupied;
    logic frame_last;

    modport source (output valid, output inflated_occupied, output frame_last, input ready);
    modport sink (input valid, input inflated_occupied, input frame_last, output ready);
endinterface

interface dil_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dil_pkg::CFG_INDEX_W-1:0]  index;
    logic [dil_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/dil_tap_cell.sv
// One cell of the horizontal tap chain: holds one raw cell bit and masks it.
module dil_tap_cell #(
    parameter int IDX  = 0,
    parameter int CMPW = 12
) (
    input  logic            clk,
    input  logic            shift,
    input  logic            din,
    input  logic [CMPW-1:0] hi,
    input  logic [CMPW-1:0] width,
    input  logic [CMPW-1:0] span,
    output logic            tap,
    output logic            hit
);

    // Stream distance of the held bit from the newest item
    localparam logic [CMPW-1:0] OFFSET = CMPW'(IDX + 1);

    logic bit_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            bit_reg <= din;
        end
    end

    assign tap = bit_reg;
    // Keep the bit only if it lies in the same row and inside the window
    assign hit = bit_reg && (OFFSET <= hi) && ((OFFSET + width) > hi) && (OFFSET <= span);

endmodule

### rtl/core/dil_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dil_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/dil_out_fifo.sv
// Small result queue between the window pipeline and the output channel.
module dil_out_fifo #(
    parameter int DEPTH = dil_pkg::OUT_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  dil_pkg::result_t           push_data,
    output logic                       valid,
    input  logic                       ready,
    output dil_pkg::result_t           data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dil_pkg::result_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             pop;

    assign pop   = valid && ready;
    assign valid = (count_reg != '0);
    assign data  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/binary_square_dilation_top.sv
// Streaming binary dilation of a raster grid with a clipped square window.
// Throughput: one cell beat per clock; ready drops only while the result queue, counting the
//   beat held in stage 1, has no free slot.
// Latency: a result leaves radius*width+radius beats after its cell; its valid rises once the
//   beat that completes its window has passed the RAM read and then the queue write.
// Reset: registers return to width 1024, height 1024, radius 1, with no frame under way.
//   The column store needs no clearing pass: rows outside the current frame are masked.
module binary_square_dilation_top #(
    parameter int MAX_WIDTH  = dil_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dil_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = dil_pkg::MAX_RADIUS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    dil_cell_if.sink     cells,
    dil_result_if.source dilated,
    dil_cfg_if.sink      cfg
);

    // Widths of the stored registers and counters
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HTW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int IRW   = $clog2(MAX_HEIGHT);
    localparam int PRW   = $clog2(MAX_HEIGHT + MAX_RADIUS);
    localparam int NTAP  = 2 * MAX_RADIUS;
    localparam int VW    = 2 * MAX_RADIUS + 1;
    localparam int CMPW  = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_RADIUS + 2);
    localparam int QCW   = $clog2(dil_pkg::OUT_DEPTH + 1);

    localparam int W_RST = (dil_pkg::GRID_WIDTH_RST > MAX_WIDTH) ?
                           MAX_WIDTH : dil_pkg::GRID_WIDTH_RST;
    localparam int H_RST = (dil_pkg::GRID_HEIGHT_RST > MAX_HEIGHT) ?
                           MAX_HEIGHT : dil_pkg::GRID_HEIGHT_RST;
    localparam int R_RST = (dil_pkg::INFLATE_RADIUS_RST > MAX_RADIUS) ?
                           MAX_RADIUS : dil_pkg::INFLATE_RADIUS_RST;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WW-1:0]  width_reg,  width_next;
    logic [HTW-1:0] height_reg, height_next;
    logic [RW-1:0]  radius_reg, radius_next;

    // ------------------------------------------------------------------
    // Frame counters.
    // in_*: raster position of the next grid cell; in_done once all cells are in.
    // lead: counts the first radius beats, before the first window center exists.
    // p_*:  window center whose row gets its horizontal OR on this beat. The
    //       output cell sits radius rows above it, in the same column.
    // ------------------------------------------------------------------
    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [IRW-1:0] in_row_reg,  in_row_next;
    logic           in_done_reg, in_done_next;
    logic [RW-1:0]  lead_reg,    lead_next;
    logic [CW-1:0]  p_col_reg,   p_col_next;
    logic [PRW-1:0] p_row_reg,   p_row_next;

    // Stage 1: column store read returns, vertical OR, write-back
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic            s1_last_reg;
    logic            s1_h_reg;
    logic            s1_fwd_reg;
    logic [VW-1:0]   s1_vmask_reg;
    logic [CW-1:0]   s1_col_reg;
    logic [NTAP-1:0] lastw_reg;

    logic            cfg_fire;
    logic            in_fire;
    logic            take;
    logic            active;
    logic [CMPW-1:0] w_c, h_c, r_c, span_c, hi_c, prow_c;
    logic            in_col_end, in_row_end, p_col_end;
    logic            emit0, last0;
    logic            cur_hit;
    logic            h0;
    logic [VW-1:0]   vmask0;
    logic [NTAP-1:0] tap;
    logic [NTAP-1:0] tap_hit;
    logic [NTAP-1:0] chain_in;
    logic [31:0]     cfg_data32;
    logic [31:0]     cfg_rad32;

    logic [NTAP-1:0] ram_rdata;
    logic [NTAP-1:0] col_hist;
    logic [VW-1:0]   col_vec;
    logic            s1_result;

    dil_pkg::result_t push_data;
    dil_pkg::result_t head;
    logic             q_valid;
    logic [QCW-1:0]   q_count;
    logic [QCW:0]     q_occupancy;

    // ------------------------------------------------------------------
    // Handshakes. Take a cell beat while the queue has room for it and for
    // the beat still in stage 1, so stage 1 never pushes a result into a full queue.
    // ------------------------------------------------------------------
    assign cfg.ready   = 1'b1;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign q_occupancy = {1'b0, q_count} + (QCW + 1)'(s1_valid_reg);
    assign cells.ready = (q_occupancy < (QCW + 1)'(dil_pkg::OUT_DEPTH));
    assign in_fire     = cells.valid && cells.ready;

    // Drain beats before the frame is complete are dropped without effect;
    // any beat after it acts as a drain.
    assign take   = in_fire && (in_done_reg || !cells.mode);
    assign active = (lead_reg == radius_reg);

    assign w_c    = CMPW'(width_reg);
    assign h_c    = CMPW'(height_reg);
    assign r_c    = CMPW'(radius_reg);
    assign span_c = r_c + r_c;
    assign hi_c   = CMPW'(p_col_reg) + r_c;
    assign prow_c = CMPW'(p_row_reg);

    assign in_col_end = ((CMPW'(in_col_reg) + CMPW'(1)) == w_c);
    assign in_row_end = ((CMPW'(in_row_reg) + CMPW'(1)) == h_c);
    assign p_col_end  = ((CMPW'(p_col_reg) + CMPW'(1)) == w_c);
    assign emit0      = active && (prow_c >= r_c);
    assign last0      = emit0 && p_col_end && ((prow_c + CMPW'(1)) == (h_c + r_c));

    // ------------------------------------------------------------------
    // Horizontal pass: the tap chain holds the last 2*MAX_RADIUS raw bits;
    // the newest bit is the beat being taken. Each tap masks itself to the
    // row and the window of the current center.
    // ------------------------------------------------------------------
    assign chain_in = {tap[NTAP-2:0], cells.cell_occupied};

    for (genvar g = 0; g < NTAP; g++)
    begin : g_tap
        dil_tap_cell #(
            .IDX  (g),
            .CMPW (CMPW)
        ) u_tap (
            .clk   (clk),
            .shift (take),
            .din   (chain_in[g]),
            .hi    (hi_c),
            .width (w_c),
            .span  (span_c),
            .tap   (tap[g]),
            .hit   (tap_hit[g])
        );
    end

    // The newest bit sits at offset zero: keep it unless it spilled into the next row
    assign cur_hit = cells.cell_occupied && (w_c > hi_c);
    assign h0      = cur_hit || (|tap_hit);

    // Vertical mask: bit k stands for the center row minus k; keep rows in the grid and the window
    always_comb
    begin
        for (int k = 0; k < VW; k++)
        begin
            vmask0[k] = (CMPW'(k) <= prow_c) && ((CMPW'(k) + h_c) > prow_c) &&
                        (CMPW'(k) <= span_c);
        end
    end

    // ------------------------------------------------------------------
    // Control next state
    // ------------------------------------------------------------------
    assign cfg_data32 = 32'(cfg.data);
    assign cfg_rad32  = 32'(cfg.data[dil_pkg::RADIUS_FIELD_W-1:0]);

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        radius_next  = radius_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        lead_next    = lead_reg;
        p_col_next   = p_col_reg;
        p_row_next   = p_row_reg;

        if (cfg_fire)
        begin
            case (cfg.index)
                dil_pkg::REG_GRID_WIDTH:
                begin
                    if (cfg_data32 == 32'd0)
                    begin
                        width_next = WW'(1);
                    end
                    else if (cfg_data32 > 32'(MAX_WIDTH))
                    begin
                        width_next = WW'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = WW'(cfg_data32);
                    end
                end
                dil_pkg::REG_GRID_HEIGHT:
                begin
                    if (cfg_data32 == 32'd0)
                    begin
                        height_next = HTW'(1);
                    end
                    else if (cfg_data32 > 32'(MAX_HEIGHT))
                    begin
                        height_next = HTW'(MAX_HEIGHT);
                    end
                    else
                    begin
                        height_next = HTW'(cfg_data32);
                    end
                end
                dil_pkg::REG_INFLATE_RADIUS:
                begin
                    if (cfg_rad32 > 32'(MAX_RADIUS))
                    begin
                        radius_next = RW'(MAX_RADIUS);
                    end
                    else
                    begin
                        radius_next = RW'(cfg_rad32);
                    end
                end
                default:
                begin
                    // Unknown index: registers hold, the frame still aborts
                end
            endcase
            // Any write drops the frame under way
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            lead_next    = '0;
            p_col_next   = '0;
            p_row_next   = '0;
        end
        else if (take)
        begin
            // Advance the raster position of incoming grid cells
            if (!in_done_reg)
            begin
                if (in_col_end)
                begin
                    in_col_next = '0;
                    if (in_row_end)
                    begin
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + IRW'(1);
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end

            // Advance the window center once the lead-in is over
            if (!active)
            begin
                lead_next = lead_reg + RW'(1);
            end
            else if (p_col_end)
            begin
                p_col_next = '0;
                p_row_next = p_row_reg + PRW'(1);
            end
            else
            begin
                p_col_next = p_col_reg + CW'(1);
            end

            // Final cell of the frame: return to the idle frame state
            if (last0)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                in_done_next = 1'b0;
                lead_next    = '0;
                p_col_next   = '0;
                p_row_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WW'(W_RST);
            height_reg   <= HTW'(H_RST);
            radius_reg   <= RW'(R_RST);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_done_reg  <= 1'b0;
            lead_reg     <= '0;
            p_col_reg    <= '0;
            p_row_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            radius_reg   <= radius_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_done_reg  <= in_done_next;
            lead_reg     <= lead_next;
            p_col_reg    <= p_col_next;
            p_row_reg    <= p_row_next;
            s1_valid_reg <= take && active && !cfg_fire;
        end
    end

    // Stage 1 payload. Forward the previous write-back when it targets the
    // same column as this read (one-column grids).
    always_ff @(posedge clk)
    begin
        s1_emit_reg  <= emit0;
        s1_last_reg  <= last0;
        s1_h_reg     <= h0;
        s1_vmask_reg <= vmask0;
        s1_col_reg   <= p_col_reg;
        s1_fwd_reg   <= s1_valid_reg && (s1_col_reg == p_col_reg);
        if (s1_valid_reg)
        begin
            lastw_reg <= col_vec[NTAP-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Column store: per column, horizontal ORs of the last 2*MAX_RADIUS rows,
    // newest in bit 0. Read on the beat, written back in the cycle after it.
    // ------------------------------------------------------------------
    dil_ram #(
        .WIDTH (NTAP),
        .DEPTH (MAX_WIDTH)
    ) u_col_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (col_vec[NTAP-1:0]),
        .re    (take && active),
        .raddr (p_col_reg),
        .rdata (ram_rdata)
    );

    assign col_hist  = s1_fwd_reg ? lastw_reg : ram_rdata;
    assign col_vec   = {col_hist, s1_h_reg};
    assign s1_result = |(col_vec & s1_vmask_reg);

    assign push_data.inflated_occupied = s1_result;
    assign push_data.frame_last        = s1_last_reg;

    // ------------------------------------------------------------------
    // Result queue: decouples the pipeline from output back-pressure
    // ------------------------------------------------------------------
    dil_out_fifo #(
        .DEPTH (dil_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg && s1_emit_reg),
        .push_data (push_data),
        .valid     (q_valid),
        .ready     (dilated.ready),
        .data      (head),
        .count     (q_count)
    );

    assign dilated.valid             = q_valid;
    assign dilated.inflated_occupied = head.inflated_occupied;
    assign dilated.frame_last        = head.frame_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg) |-> (q_count < QCW'(dil_pkg::OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last0) |=> (!in_done_reg && (p_row_reg == '0) && (lead_reg == '0)))
        else $error("counters not cleared after the final cell");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit0) |-> active)
        else $error("result emitted before the first window center");

endmodule
